// File: rtl/sks_pkg.sv
`default_nettype none

package sks_pkg;

   // Fixed field widths of the item and register formats
   localparam int unsigned MEAS_W = 33;
   localparam int unsigned EST_W  = 49;
   localparam int unsigned GAIN_W = 17;
   localparam int unsigned COV_W  = 33;
   localparam int unsigned NOISE_W = 32;
   localparam int unsigned PT_W   = 34;
   localparam int unsigned DEN_W  = 35;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASURE_NOISE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_ESTIMATE = 2'd2;

   // Register reset values
   localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST = 32'd655;
   localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 32'd65536;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRED,
      ST_DEN,
      ST_DIV,
      ST_DIFF,
      ST_MULE,
      ST_SUME,
      ST_ONEK,
      ST_MULC,
      ST_DONE
   } state_type;

   // Shared adder operations
   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   // Noise registers seen by the sequencer
   typedef struct packed {
      logic [NOISE_W-1:0] process_noise;
      logic [NOISE_W-1:0] measure_noise;
   } noise_type;

   // Restart request from the register file
   typedef struct packed {
      logic             restart;
      logic [EST_W-1:0] restart_est;
   } restart_type;

   // Result item, estimate in the lowest bits
   typedef struct packed {
      logic [COV_W-1:0]  covariance;
      logic [GAIN_W-1:0] gain;
      logic [EST_W-1:0]  estimate;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/sks_alu.sv
`default_nettype none

module sks_alu #(
   parameter int unsigned W = 60
) (
   input  wire  sks_pkg::alu_op_type op,
   input  wire  logic signed [W-1:0] opa,
   input  wire  logic signed [W-1:0] opb,
   output logic signed [W-1:0]       sum,
   output logic signed [W-1:0]       half
);
   import sks_pkg::*;

   // Add or subtract, then offer the sum halved with floor
   always_comb begin
      case (op)
         ALU_SUB: sum = opa - opb;
         default: sum = opa + opb;
      endcase
      half = {sum[W-1], sum[W-1:1]};
   end

endmodule

`default_nettype wire

// File: rtl/sks_core.sv
`default_nettype none

module sks_core #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire  logic                            clock,
   input  wire  logic                            reset,
   input  wire  logic                            start,
   input  wire  logic [sks_pkg::MEAS_W-1:0]      meas,
   input  wire  sks_pkg::noise_type              noise,
   input  wire  sks_pkg::restart_type            ctrl,
   input  wire  logic                            out_free,
   output logic                                  idle,
   output logic                                  done,
   output sks_pkg::result_type                   result
);
   import sks_pkg::*;

   localparam int unsigned F   = FRAC_BITS;
   localparam int unsigned SW  = (MEAS_W + F > EST_W) ? MEAS_W + F : EST_W;
   localparam int unsigned DW  = SW + 1;
   localparam int unsigned AW  = DW + 2;
   localparam int unsigned CW  = $clog2(F + 1);
   localparam logic [CW-1:0] LAST = CW'(F);

   state_type state_ff, state_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [MEAS_W-1:0]      meas_ff, meas_in;
   logic [PT_W-1:0]        pt_ff, pt_in;
   logic [DEN_W-1:0]       den_ff, den_in;
   logic [DEN_W-1:0]       rem_ff, rem_in;
   logic [F:0]             k_ff, k_in;
   logic [F:0]             mbits_ff, mbits_in;
   logic signed [DW-1:0]   diff_ff, diff_in;
   logic signed [DW:0]     acc_ff, acc_in;
   logic signed [EST_W-1:0] est_ff, est_in;
   logic [COV_W-1:0]       cov_ff, cov_in;

   alu_op_type             op;
   logic signed [AW-1:0]   opa, opb, alu_sum, alu_half;
   logic signed [AW-1:0]   div_x, mcand;
   logic                   qbit;
   logic                   est_ovf, cov_ovf;
   logic [F+GAIN_W:0]      k_wide;

   localparam logic [COV_W-1:0] COV_ONE = {{(COV_W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
   localparam logic signed [AW-1:0] ONE_A = {{(AW-F-1){1'b0}}, 1'b1, {F{1'b0}}};

   sks_alu #(.W(AW)) u_alu (
      .op   (op),
      .opa  (opa),
      .opb  (opb),
      .sum  (alu_sum),
      .half (alu_half)
   );

   // Overflow checks on the adder output
   assign est_ovf = (alu_sum[AW-1:EST_W-1] != {(AW-EST_W+1){1'b0}}) &&
                    (alu_sum[AW-1:EST_W-1] != {(AW-EST_W+1){1'b1}});
   assign cov_ovf = (alu_sum[AW-1:COV_W] != {(AW-COV_W){1'b0}});

   // Divider partial remainder: the first step takes pt itself
   assign div_x = (cnt_ff == '0) ? {{(AW-PT_W){1'b0}}, pt_ff}
                                 : {{(AW-DEN_W-1){1'b0}}, rem_ff, 1'b0};
   assign mcand = (state_ff == ST_MULE) ? {{2{diff_ff[DW-1]}}, diff_ff}
                                        : {{(AW-PT_W){1'b0}}, pt_ff};
   assign qbit  = !alu_sum[AW-1] && (den_ff != '0);

   // Sequence the shared adder through predict, divide, estimate update, 1-K and two multiplies
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      meas_in  = meas_ff;
      pt_in    = pt_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      k_in     = k_ff;
      mbits_in = mbits_ff;
      diff_in  = diff_ff;
      acc_in   = acc_ff;
      est_in   = est_ff;
      cov_in   = cov_ff;
      op       = ALU_ADD;
      opa      = '0;
      opb      = '0;
      done     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               meas_in  = meas;
               state_in = ST_PRED;
            end
         end
         ST_PRED: begin
            opa      = {{(AW-COV_W){1'b0}}, cov_ff};
            opb      = {{(AW-NOISE_W){1'b0}}, noise.process_noise};
            pt_in    = alu_sum[PT_W-1:0];
            state_in = ST_DEN;
         end
         ST_DEN: begin
            opa      = {{(AW-PT_W){1'b0}}, pt_ff};
            opb      = {{(AW-NOISE_W){1'b0}}, noise.measure_noise};
            den_in   = alu_sum[DEN_W-1:0];
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // Restoring divide, one quotient bit a cycle, MSB first
            op     = ALU_SUB;
            opa    = div_x;
            opb    = {{(AW-DEN_W){1'b0}}, den_ff};
            rem_in = qbit ? alu_sum[DEN_W-1:0] : div_x[DEN_W-1:0];
            k_in   = {k_ff[F-1:0], qbit};
            if (cnt_ff == LAST) begin
               state_in = ST_DIFF;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIFF: begin
            op       = ALU_SUB;
            opa      = {{(AW-MEAS_W-F){meas_ff[MEAS_W-1]}}, meas_ff, {F{1'b0}}};
            opb      = {{(AW-EST_W){est_ff[EST_W-1]}}, est_ff};
            diff_in  = alu_sum[DW-1:0];
            mbits_in = k_ff;
            acc_in   = '0;
            cnt_in   = '0;
            state_in = ST_MULE;
         end
         ST_MULE, ST_MULC: begin
            // Shift-add multiply, LSB first, halving after each fraction bit
            opa      = {acc_ff[DW], acc_ff};
            opb      = mbits_ff[0] ? mcand : '0;
            mbits_in = mbits_ff >> 1;
            if (cnt_ff == LAST) begin
               if (state_ff == ST_MULE) begin
                  acc_in   = alu_sum[DW:0];
                  state_in = ST_SUME;
               end else begin
                  cov_in   = cov_ovf ? {COV_W{1'b1}} : alu_sum[COV_W-1:0];
                  state_in = ST_DONE;
               end
            end else begin
               acc_in = alu_half[DW:0];
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SUME: begin
            // Apply the correction and clamp to the estimate range
            opa = {{(AW-EST_W){est_ff[EST_W-1]}}, est_ff};
            opb = {acc_ff[DW], acc_ff};
            if (est_ovf) begin
               est_in = alu_sum[AW-1] ? {1'b1, {(EST_W-1){1'b0}}}
                                      : {1'b0, {(EST_W-1){1'b1}}};
            end else begin
               est_in = alu_sum[EST_W-1:0];
            end
            state_in = ST_ONEK;
         end
         ST_ONEK: begin
            op       = ALU_SUB;
            opa      = ONE_A;
            opb      = {{(AW-F-1){1'b0}}, k_ff};
            mbits_in = alu_sum[F:0];
            acc_in   = '0;
            cnt_in   = '0;
            state_in = ST_MULC;
         end
         ST_DONE: begin
            done = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // Restart the filter on a restart request from a register write
      if (ctrl.restart) begin
         est_in = ctrl.restart_est;
         cov_in = COV_ONE;
      end
   end

   // Control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         est_ff   <= '0;
         cov_ff   <= COV_ONE;
      end else begin
         state_ff <= state_in;
         est_ff   <= est_in;
         cov_ff   <= cov_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      meas_ff  <= meas_in;
      pt_ff    <= pt_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      k_ff     <= k_in;
      mbits_ff <= mbits_in;
      diff_ff  <= diff_in;
      acc_ff   <= acc_in;
   end

   // Gain field keeps its low bits
   assign k_wide = {{GAIN_W{1'b0}}, k_ff};

   assign idle              = (state_ff == ST_IDLE);
   assign result.estimate   = est_ff;
   assign result.gain       = k_wide[GAIN_W-1:0];
   assign result.covariance = cov_ff;

endmodule

`default_nettype wire

// File: rtl/scalar_kalman_smoother.sv
// Items are taken one at a time: req_tready stays low from an item's accept on req_
//   until its result moves to the output register. One shared adder runs the gain
//   divide and the two shift-add multiplies one bit per cycle each.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active high): registers to Q=655, R=1.0, initial estimate 0;
//   estimate 0, covariance 1.0, no result pending. Known-index writes restart the filter.
`default_nettype none

module scalar_kalman_smoother #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire  logic                              clock,
   input  wire  logic                              reset,
   // req_tdata: measurement[32:0], zero pad [39:33]
   input  wire  logic                              req_tvalid,
   output logic                                    req_tready,
   input  wire  logic [39:0]                       req_tdata,
   // rsp_tdata: estimate[48:0], gain[65:49], covariance[98:66], zero pad [103:99]
   output logic                                    rsp_tvalid,
   input  wire  logic                              rsp_tready,
   output logic [103:0]                            rsp_tdata,
   input  wire  logic                              csr_valid,
   output logic                                    csr_ready,
   input  wire  logic [sks_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  logic [sks_pkg::EST_W-1:0]         csr_data
);
   import sks_pkg::*;

   logic [NOISE_W-1:0] q_ff, q_in;
   logic [NOISE_W-1:0] r_ff, r_in;
   logic [EST_W-1:0]   init_ff, init_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff, rsp_data_in;

   noise_type          noise;
   restart_type        ctrl;
   result_type         result;
   logic               core_idle, core_done, out_free, csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Decode register writes; a known index also restarts the filter
   always_comb begin
      q_in         = q_ff;
      r_in         = r_ff;
      init_in      = init_ff;
      ctrl.restart = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            CSR_PROCESS_NOISE: begin
               q_in         = csr_data[NOISE_W-1:0];
               ctrl.restart = 1'b1;
            end
            CSR_MEASURE_NOISE: begin
               r_in         = csr_data[NOISE_W-1:0];
               ctrl.restart = 1'b1;
            end
            CSR_INITIAL_ESTIMATE: begin
               init_in      = csr_data;
               ctrl.restart = 1'b1;
            end
            default: begin
               ctrl.restart = 1'b0;
            end
         endcase
      end
      ctrl.restart_est = init_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff    <= PROCESS_NOISE_RST;
         r_ff    <= MEASURE_NOISE_RST;
         init_ff <= '0;
      end else begin
         q_ff    <= q_in;
         r_ff    <= r_in;
         init_ff <= init_in;
      end
   end

   assign noise.process_noise = q_ff;
   assign noise.measure_noise = r_ff;

   sks_core #(.FRAC_BITS(FRAC_BITS)) u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (req_tvalid && req_tready),
      .meas     (req_tdata[MEAS_W-1:0]),
      .noise    (noise),
      .ctrl     (ctrl),
      .out_free (out_free),
      .idle     (core_idle),
      .done     (core_done),
      .result   (result)
   );

   assign req_tready = core_idle;

   // Output register: load when empty or draining, hold while stalled
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = core_done;
         if (core_done) begin
            rsp_data_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff};

endmodule

`default_nettype wire

// File: rtl/sks_checker.sv
`default_nettype none

module sks_checker #(
   parameter int unsigned FRAC_BITS = 16
) (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic [39:0]  req_tdata,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [103:0] rsp_tdata,
   input wire logic         csr_valid,
   input wire logic         csr_ready
);

   logic [16:0] gain;
   assign gain = rsp_tdata[65:49];

   // No result is pending out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // One item at a time: the block is busy right after taking one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item taken while previous item in progress");

   // A stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // Gain never exceeds 1.0 where it fits the field
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (FRAC_BITS <= 16) && (req_tdata[39:33] == 7'd0 || !req_tvalid)
       && csr_ready) |-> (gain <= 17'(1 << FRAC_BITS)))
      else $error("gain above one");

   // Register writes are always taken
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write refused");

endmodule

bind scalar_kalman_smoother sks_checker #(.FRAC_BITS(FRAC_BITS)) u_sks_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);

`default_nettype wire
